### design/lennard_jones_force_accumulate_unit_macros.svh
// Assertion macros used by the checker file of the force accumulate unit
`ifndef LENNARD_JONES_FORCE_ACCUMULATE_UNIT_MACROS_SVH
`define LENNARD_JONES_FORCE_ACCUMULATE_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define LJFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define LJFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ljfa_pkg.sv
// Shared types, codes and constants of the force accumulate unit
package ljfa_pkg;

  localparam int ACC_WIDTH     = 48;
  localparam int FRAC_BITS_DEF = 20;
  localparam int POS_W         = 32;
  localparam int CFG_W         = 32;
  localparam int SH_W          = 6;
  localparam int REG_AW        = 5;

  // Register indexes
  localparam logic [2:0] REG_EPSILON = 3'd0;
  localparam logic [2:0] REG_SIGMA_SQ = 3'd1;
  localparam logic [2:0] REG_SIGMA_POW6 = 3'd2;
  localparam logic [2:0] REG_SIGMA_POW12 = 3'd3;
  localparam logic [2:0] REG_CUTOFF = 3'd4;

  // Datapath operations
  localparam logic [2:0] OP_IDLE = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_POST = 3'd3;
  localparam logic [2:0] OP_DIV_INV = 3'd4;
  localparam logic [2:0] OP_DIV_N = 3'd5;
  localparam logic [2:0] OP_SQRT = 3'd6;
  localparam logic [2:0] OP_EMIT = 3'd7;

  // Multiply kinds, one per product of the force chain
  localparam logic [3:0] MK_INIT = 4'd0;
  localparam logic [3:0] MK_SQ = 4'd1;
  localparam logic [3:0] MK_INV2 = 4'd2;
  localparam logic [3:0] MK_P3 = 4'd3;
  localparam logic [3:0] MK_P4 = 4'd4;
  localparam logic [3:0] MK_TA = 4'd5;
  localparam logic [3:0] MK_TB = 4'd6;
  localparam logic [3:0] MK_G = 4'd7;
  localparam logic [3:0] MK_S = 4'd8;
  localparam logic [3:0] MK_N = 4'd9;

  typedef struct packed {
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic signed [POS_W-1:0] target_z;
    logic signed [POS_W-1:0] other_x;
    logic signed [POS_W-1:0] other_y;
    logic signed [POS_W-1:0] other_z;
    logic signed [POS_W-1:0] init_accel_x;
    logic signed [POS_W-1:0] init_accel_y;
    logic signed [POS_W-1:0] init_accel_z;
    logic                    first_pair;
    logic                    last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] accel_x;
    logic signed [ACC_WIDTH-1:0] accel_y;
    logic signed [ACC_WIDTH-1:0] accel_z;
    logic                        overflow;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] epsilon;
    logic [CFG_W-1:0] sigma_sq;
    logic [CFG_W-1:0] sigma_pow6;
    logic [CFG_W-1:0] sigma_pow12;
    logic             cutoff_enable;
  } cfg_t;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] kind;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic first;
    logic last;
    logic skip;
    logic mag_nz;
    logic out_free;
  } stat_t;

endpackage

### design/ljfa_regs.sv
// Configuration registers behind the APB-style port
module ljfa_regs #(
  parameter int FRAC_BITS = ljfa_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ljfa_pkg::REG_AW-1:0]    paddr,
  input  logic [ljfa_pkg::CFG_W-1:0]     pwdata,
  output logic [ljfa_pkg::CFG_W-1:0]     prdata,
  output logic                           pready,
  output ljfa_pkg::cfg_t                 cfg
);

  localparam logic [ljfa_pkg::CFG_W-1:0] ONE = ljfa_pkg::CFG_W'(1) << FRAC_BITS;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ljfa_pkg::REG_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.epsilon       <= ONE;
      cfg.sigma_sq      <= ONE;
      cfg.sigma_pow6    <= ONE;
      cfg.sigma_pow12   <= ONE;
      cfg.cutoff_enable <= 1'b0;
    end else if (wr) begin
      case (idx)
        ljfa_pkg::REG_EPSILON:     cfg.epsilon <= pwdata;
        ljfa_pkg::REG_SIGMA_SQ:    cfg.sigma_sq <= pwdata;
        ljfa_pkg::REG_SIGMA_POW6:  cfg.sigma_pow6 <= pwdata;
        ljfa_pkg::REG_SIGMA_POW12: cfg.sigma_pow12 <= pwdata;
        ljfa_pkg::REG_CUTOFF:      cfg.cutoff_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      ljfa_pkg::REG_EPSILON:     prdata = cfg.epsilon;
      ljfa_pkg::REG_SIGMA_SQ:    prdata = cfg.sigma_sq;
      ljfa_pkg::REG_SIGMA_POW6:  prdata = cfg.sigma_pow6;
      ljfa_pkg::REG_SIGMA_POW12: prdata = cfg.sigma_pow12;
      ljfa_pkg::REG_CUTOFF:      prdata = ljfa_pkg::CFG_W'(cfg.cutoff_enable);
      default:                   prdata = '0;
    endcase
  end

endmodule

### design/ljfa_mul.sv
// Saturating 64x64 multiply with a right shift, four 32x32 partial products
module ljfa_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [63:0]                 a,
  input  logic [63:0]                 b,
  input  logic [ljfa_pkg::SH_W-1:0]   sh,
  output logic [63:0]                 res,
  output logic                        done
);

  localparam logic [2:0] LAST_PP = 3'd4;

  logic [63:0]                ma;
  logic [63:0]                mb;
  logic [ljfa_pkg::SH_W-1:0]  msh;
  logic [127:0]               prod;
  logic [2:0]                 step;
  logic                       busy;
  logic [31:0]                ah;
  logic [31:0]                bh;
  logic [63:0]                pp;
  logic [7:0]                 pp_amt;
  logic [127:0]               pp_ext;
  logic [127:0]               shifted;

  // Pick the halves for this partial product
  assign ah      = step[1] ? ma[63:32] : ma[31:0];
  assign bh      = step[0] ? mb[63:32] : mb[31:0];
  assign pp      = 64'(ah) * 64'(bh);
  assign pp_amt  = (8'(step[1]) + 8'(step[0])) << 5;
  assign pp_ext  = {64'b0, pp} << pp_amt;
  assign shifted = prod >> msh;

  // Control: count partial products, then the shift beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LAST_PP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  // Operands, product and the saturated result
  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= a;
      mb   <= b;
      msh  <= sh;
      prod <= '0;
    end else if (busy) begin
      if (step == LAST_PP) begin
        res <= (|shifted[127:64]) ? '1 : shifted[63:0];
      end else begin
        prod <= prod + pp_ext;
      end
    end
  end

endmodule

### design/ljfa_dp.sv
// Datapath: pair registers, multiplier, divider, square root, accumulators, result register
module ljfa_dp #(
  parameter int FRAC_BITS = ljfa_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ljfa_pkg::cmd_t      cmd,
  input  ljfa_pkg::in_item_t  in_item,
  input  ljfa_pkg::cfg_t      cfg,
  input  logic                out_ready,
  output ljfa_pkg::stat_t     stat,
  output logic                out_valid,
  output ljfa_pkg::out_item_t out_item
);

  localparam int ACC_W    = ljfa_pkg::ACC_WIDTH;
  localparam int ACC_FRAC = ACC_W / 2;
  localparam int INV_K    = 2 * FRAC_BITS + ACC_FRAC;
  localparam int SH_W     = ljfa_pkg::SH_W;
  localparam logic [127:0] INV_NUM = 128'd1 << INV_K;
  localparam logic [63:0] ONE_ACC = 64'd1 << ACC_FRAC;
  localparam logic [SH_W-1:0] SH_ACC = SH_W'(ACC_FRAC);
  localparam logic [SH_W-1:0] SH_FRAC = SH_W'(FRAC_BITS);
  localparam logic [SH_W-1:0] SH_FRAC1 = SH_W'(FRAC_BITS + 1);
  localparam logic [SH_W-1:0] SH_UNIT = SH_W'(31);
  localparam logic [ACC_W-1:0] TOP = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] MASK = '1;

  // Pair registers
  logic        first;
  logic        last;
  logic [31:0] mag [3];
  logic        dneg [3];
  logic [31:0] imag [3];
  logic        ineg [3];
  logic [63:0] sq [3];
  logic [63:0] r2;
  logic [63:0] p3;
  logic [63:0] p4;
  logic [63:0] ta;
  logic [63:0] diff;
  logic        sneg;
  logic [63:0] g;
  logic [63:0] s;
  logic [ACC_W-1:0] sums [3];
  logic        sat_seen;

  // Input fields by component
  logic [31:0] tgt [3];
  logic [31:0] oth [3];
  logic [31:0] ini [3];
  logic [32:0] dd [3];
  logic [32:0] iv [3];

  // Multiplier port
  logic                mul_start;
  logic [63:0]         mul_a;
  logic [63:0]         mul_b;
  logic [SH_W-1:0]     mul_sh;
  logic [63:0]         mres;
  logic                mul_done;

  // Divider
  logic [63:0]  d_rem;
  logic [63:0]  dq;
  logic [63:0]  d_lo;
  logic [63:0]  d_den;
  logic [5:0]   d_cnt;
  logic         d_busy;
  logic         d_done;
  logic         d_go;
  logic [127:0] d_num;
  logic [63:0]  d_den_in;
  logic [63:0]  d_rsh;
  logic         d_take;

  // Square root
  logic [63:0] sv;
  logic [63:0] sres;
  logic [63:0] sbit;
  logic        s_busy;
  logic        s_done;
  logic [63:0] s_trial;

  // Misc combinational
  logic [63:0]      eps48;
  logic [63:0]      sig25;
  logic [63:0]      lim;
  logic [64:0]      r2_sum;
  logic             acc_neg;
  logic [ACC_W-1:0] acc_u;
  logic [ACC_W-1:0] acc_room;
  logic             acc_sat;
  logic [ACC_W-1:0] acc_u_new;
  logic [ACC_W-1:0] acc_new;

  assign tgt[0] = in_item.target_x;
  assign tgt[1] = in_item.target_y;
  assign tgt[2] = in_item.target_z;
  assign oth[0] = in_item.other_x;
  assign oth[1] = in_item.other_y;
  assign oth[2] = in_item.other_z;
  assign ini[0] = in_item.init_accel_x;
  assign ini[1] = in_item.init_accel_y;
  assign ini[2] = in_item.init_accel_z;

  // Offsets and starting accelerations as sign and magnitude
  for (genvar i = 0; i < 3; i++) begin : g_comp
    assign dd[i] = {tgt[i][31], tgt[i]} - {oth[i][31], oth[i]};
    assign iv[i] = {ini[i][31], ini[i]};
  end

  // Select multiply operands for the current product
  always_comb begin
    case (cmd.kind)
      ljfa_pkg::MK_INIT: begin
        mul_a = 64'(imag[cmd.idx]); mul_b = ONE_ACC; mul_sh = SH_FRAC;
      end
      ljfa_pkg::MK_SQ: begin
        mul_a = 64'(mag[cmd.idx]); mul_b = 64'(mag[cmd.idx]); mul_sh = '0;
      end
      ljfa_pkg::MK_INV2: begin
        mul_a = dq; mul_b = dq; mul_sh = SH_ACC;
      end
      ljfa_pkg::MK_P3: begin
        mul_a = mres; mul_b = dq; mul_sh = SH_ACC;
      end
      ljfa_pkg::MK_P4: begin
        mul_a = p3; mul_b = dq; mul_sh = SH_ACC;
      end
      ljfa_pkg::MK_TA: begin
        mul_a = 64'(cfg.sigma_pow12); mul_b = p3; mul_sh = SH_FRAC;
      end
      ljfa_pkg::MK_TB: begin
        mul_a = 64'(cfg.sigma_pow6); mul_b = ONE_ACC; mul_sh = SH_FRAC1;
      end
      ljfa_pkg::MK_G: begin
        mul_a = eps48; mul_b = p4; mul_sh = SH_FRAC;
      end
      ljfa_pkg::MK_S: begin
        mul_a = g; mul_b = diff; mul_sh = SH_ACC;
      end
      ljfa_pkg::MK_N: begin
        mul_a = s; mul_b = sres; mul_sh = SH_UNIT;
      end
      default: begin
        mul_a = '0; mul_b = '0; mul_sh = '0;
      end
    endcase
  end

  assign mul_start = (cmd.op == ljfa_pkg::OP_MUL);

  ljfa_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .res   (mres),
    .done  (mul_done)
  );

  // Scaled constants and the cutoff limit
  assign eps48  = (64'(cfg.epsilon) << 5) + (64'(cfg.epsilon) << 4);
  assign sig25  = (64'(cfg.sigma_sq) << 4) + (64'(cfg.sigma_sq) << 3) + 64'(cfg.sigma_sq);
  assign lim    = sig25 << (FRAC_BITS - 2);
  assign r2_sum = {1'b0, r2} + {1'b0, mres};

  // Saturating add into the selected accumulator, offset binary form
  assign acc_neg  = (cmd.kind == ljfa_pkg::MK_INIT) ? ineg[cmd.idx]
                                                    : (sneg ^ dneg[cmd.idx]);
  assign acc_u    = sums[cmd.idx] ^ TOP;
  assign acc_room = MASK - acc_u;
  always_comb begin
    if (!acc_neg) begin
      acc_sat   = mres > 64'(acc_room);
      acc_u_new = acc_sat ? MASK : acc_u + mres[ACC_W-1:0];
    end else begin
      acc_sat   = mres > 64'(acc_u);
      acc_u_new = acc_sat ? '0 : acc_u - mres[ACC_W-1:0];
    end
  end
  assign acc_new = acc_u_new ^ TOP;

  // Status to the controller
  assign stat.mul_done  = mul_done;
  assign stat.div_done  = d_done;
  assign stat.sqrt_done = s_done;
  assign stat.first     = first;
  assign stat.last      = last;
  assign stat.skip      = (r2 == '0) || (cfg.cutoff_enable && (r2 > lim));
  assign stat.mag_nz    = (mag[cmd.idx] != '0);
  assign stat.out_free  = !out_valid || out_ready;

  // Accumulators, overflow flag and the result register handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sums[i] <= '0;
      end
      sat_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == ljfa_pkg::OP_LOAD && in_item.first_pair) begin
        for (int i = 0; i < 3; i++) begin
          sums[i] <= '0;
        end
        sat_seen <= 1'b0;
      end
      if (cmd.op == ljfa_pkg::OP_POST &&
          (cmd.kind == ljfa_pkg::MK_INIT || cmd.kind == ljfa_pkg::MK_N)) begin
        sums[cmd.idx] <= acc_new;
        if (acc_sat) begin
          sat_seen <= 1'b1;
        end
      end
      if (cmd.op == ljfa_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pair payload: load the beat, then hold the products of the chain
  always_ff @(posedge clk) begin
    case (cmd.op)
      ljfa_pkg::OP_LOAD: begin
        first <= in_item.first_pair;
        last  <= in_item.last_pair;
        r2    <= '0;
        for (int i = 0; i < 3; i++) begin
          dneg[i] <= dd[i][32];
          mag[i]  <= dd[i][32] ? 32'(33'd0 - dd[i]) : dd[i][31:0];
          ineg[i] <= iv[i][32];
          imag[i] <= iv[i][32] ? 32'(33'd0 - iv[i]) : iv[i][31:0];
        end
      end
      ljfa_pkg::OP_POST: begin
        case (cmd.kind)
          ljfa_pkg::MK_SQ: begin
            sq[cmd.idx] <= mres;
            r2          <= r2_sum[64] ? '1 : r2_sum[63:0];
          end
          ljfa_pkg::MK_P3: p3 <= mres;
          ljfa_pkg::MK_P4: p4 <= mres;
          ljfa_pkg::MK_TA: ta <= mres;
          ljfa_pkg::MK_TB: begin
            sneg <= mres > ta;
            diff <= (mres > ta) ? mres - ta : ta - mres;
          end
          ljfa_pkg::MK_G: g <= mres;
          ljfa_pkg::MK_S: s <= mres;
          default: ;
        endcase
      end
      ljfa_pkg::OP_EMIT: begin
        out_item.accel_x  <= sums[0];
        out_item.accel_y  <= sums[1];
        out_item.accel_z  <= sums[2];
        out_item.overflow <= sat_seen;
      end
      default: ;
    endcase
  end

  // Restoring divider, one quotient bit a beat
  assign d_go     = (cmd.op == ljfa_pkg::OP_DIV_INV) || (cmd.op == ljfa_pkg::OP_DIV_N);
  assign d_num    = (cmd.op == ljfa_pkg::OP_DIV_INV) ? INV_NUM
                                                     : ({64'b0, sq[cmd.idx]} << 62);
  assign d_den_in = r2;
  assign d_rsh    = {d_rem[62:0], d_lo[63]};
  assign d_take   = d_rem[63] || (d_rsh >= d_den);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_busy <= 1'b0;
      d_done <= 1'b0;
      d_cnt  <= '0;
    end else begin
      d_done <= 1'b0;
      if (d_go) begin
        d_cnt <= '0;
        if (d_den_in == '0 || d_num[127:64] >= d_den_in) begin
          d_done <= 1'b1;
        end else begin
          d_busy <= 1'b1;
        end
      end else if (d_busy) begin
        d_cnt <= d_cnt + 6'd1;
        if (d_cnt == '1) begin
          d_busy <= 1'b0;
          d_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_go) begin
      d_rem <= d_num[127:64];
      d_lo  <= d_num[63:0];
      d_den <= d_den_in;
      dq    <= (d_den_in == '0 || d_num[127:64] >= d_den_in) ? '1 : '0;
    end else if (d_busy) begin
      d_lo  <= d_lo << 1;
      d_rem <= d_take ? d_rsh - d_den : d_rsh;
      dq    <= {dq[62:0], d_take};
    end
  end

  // Bitwise integer square root of the quotient, two bits of input a beat
  assign s_trial = sres + sbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_busy <= 1'b0;
      s_done <= 1'b0;
    end else begin
      s_done <= 1'b0;
      if (cmd.op == ljfa_pkg::OP_SQRT) begin
        s_busy <= 1'b1;
      end else if (s_busy && sbit == 64'd1) begin
        s_busy <= 1'b0;
        s_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ljfa_pkg::OP_SQRT) begin
      sv   <= dq;
      sres <= '0;
      sbit <= 64'd1 << 62;
    end else if (s_busy) begin
      if (sv >= s_trial) begin
        sv   <= sv - s_trial;
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

endmodule

### design/ljfa_ctrl.sv
// Controller: sequences the force chain of one pair over the shared units
module ljfa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ljfa_pkg::stat_t stat,
  output ljfa_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_START     = 4'd1;
  localparam logic [3:0] S_MUL_GO    = 4'd2;
  localparam logic [3:0] S_MUL_WAIT  = 4'd3;
  localparam logic [3:0] S_POST      = 4'd4;
  localparam logic [3:0] S_CHECK     = 4'd5;
  localparam logic [3:0] S_DIVI_GO   = 4'd6;
  localparam logic [3:0] S_DIVI_WAIT = 4'd7;
  localparam logic [3:0] S_COMP      = 4'd8;
  localparam logic [3:0] S_DIVN_GO   = 4'd9;
  localparam logic [3:0] S_DIVN_WAIT = 4'd10;
  localparam logic [3:0] S_SQRT_GO   = 4'd11;
  localparam logic [3:0] S_SQRT_WAIT = 4'd12;
  localparam logic [3:0] S_EMIT      = 4'd13;

  localparam logic [1:0] LAST_IDX = 2'd2;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] kind;
  logic [3:0] kind_next;
  logic [1:0] idx;
  logic [1:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= ljfa_pkg::MK_INIT;
      idx   <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      idx   <= idx_next;
    end
  end

  // Next state and the command of this beat
  always_comb begin
    state_next = state;
    kind_next  = kind;
    idx_next   = idx;
    cmd.op     = ljfa_pkg::OP_IDLE;
    cmd.kind   = kind;
    cmd.idx    = idx;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = ljfa_pkg::OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        idx_next   = '0;
        kind_next  = stat.first ? ljfa_pkg::MK_INIT : ljfa_pkg::MK_SQ;
        state_next = S_MUL_GO;
      end
      S_MUL_GO: begin
        cmd.op     = ljfa_pkg::OP_MUL;
        state_next = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (stat.mul_done) begin
          state_next = S_POST;
        end
      end
      S_POST: begin
        cmd.op     = ljfa_pkg::OP_POST;
        state_next = S_MUL_GO;
        case (kind)
          ljfa_pkg::MK_INIT: begin
            if (idx == LAST_IDX) begin
              idx_next  = '0;
              kind_next = ljfa_pkg::MK_SQ;
            end else begin
              idx_next = idx + 2'd1;
            end
          end
          ljfa_pkg::MK_SQ: begin
            if (idx == LAST_IDX) begin
              state_next = S_CHECK;
            end else begin
              idx_next = idx + 2'd1;
            end
          end
          ljfa_pkg::MK_INV2: kind_next = ljfa_pkg::MK_P3;
          ljfa_pkg::MK_P3:   kind_next = ljfa_pkg::MK_P4;
          ljfa_pkg::MK_P4:   kind_next = ljfa_pkg::MK_TA;
          ljfa_pkg::MK_TA:   kind_next = ljfa_pkg::MK_TB;
          ljfa_pkg::MK_TB:   kind_next = ljfa_pkg::MK_G;
          ljfa_pkg::MK_G:    kind_next = ljfa_pkg::MK_S;
          ljfa_pkg::MK_S: begin
            idx_next   = '0;
            state_next = S_COMP;
          end
          ljfa_pkg::MK_N: begin
            if (idx == LAST_IDX) begin
              state_next = S_EMIT;
            end else begin
              idx_next   = idx + 2'd1;
              state_next = S_COMP;
            end
          end
          default: state_next = S_EMIT;
        endcase
      end
      S_CHECK: begin
        state_next = stat.skip ? S_EMIT : S_DIVI_GO;
      end
      S_DIVI_GO: begin
        cmd.op     = ljfa_pkg::OP_DIV_INV;
        state_next = S_DIVI_WAIT;
      end
      S_DIVI_WAIT: begin
        if (stat.div_done) begin
          kind_next  = ljfa_pkg::MK_INV2;
          state_next = S_MUL_GO;
        end
      end
      // Drop components with no offset
      S_COMP: begin
        if (stat.mag_nz) begin
          state_next = S_DIVN_GO;
        end else if (idx == LAST_IDX) begin
          state_next = S_EMIT;
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      S_DIVN_GO: begin
        cmd.op     = ljfa_pkg::OP_DIV_N;
        state_next = S_DIVN_WAIT;
      end
      S_DIVN_WAIT: begin
        if (stat.div_done) begin
          state_next = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd.op     = ljfa_pkg::OP_SQRT;
        state_next = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          kind_next  = ljfa_pkg::MK_N;
          state_next = S_MUL_GO;
        end
      end
      // On the last pair, hold until the result register is free
      S_EMIT: begin
        if (!stat.last) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.op     = ljfa_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### design/lennard_jones_force_accumulate_unit.sv
// Top level of the Lennard-Jones pair force accumulate unit
//
//   channel  | handshake                      | payload
//   in       | in_valid / in_ready            | in_item (one particle pair)
//   out      | out_valid / out_ready          | out_item (acceleration, overflow)
//   config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One pair at a time. Multiplies run on the shared 32x32 multiplier, divides on
// the one-bit restoring divider, square roots on the bitwise root unit. A pair
// skipped by cutoff or at zero distance stops after its squared offsets, and a
// first pair loads its starting acceleration first; a kept pair also takes a
// divide, square root and multiply for each nonzero offset component.
// Reset is synchronous and restores the register defaults and clears the sums.
// A finished result waits in the output register; a new pair is taken meanwhile,
// and only a later result stalls until the register is taken.
module lennard_jones_force_accumulate_unit #(
  parameter int FRAC_BITS = ljfa_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ljfa_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ljfa_pkg::out_item_t           out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ljfa_pkg::REG_AW-1:0]   paddr,
  input  logic [ljfa_pkg::CFG_W-1:0]    pwdata,
  output logic [ljfa_pkg::CFG_W-1:0]    prdata,
  output logic                          pready
);

  ljfa_pkg::cfg_t  cfg;
  ljfa_pkg::cmd_t  cmd;
  ljfa_pkg::stat_t stat;

  ljfa_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ljfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ljfa_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg       (cfg),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### design/ljfa_checker.sv
// Port-level checks of the force accumulate unit, bound to the top level
`include "lennard_jones_force_accumulate_unit_macros.svh"

module ljfa_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input ljfa_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input ljfa_pkg::out_item_t out_item
);

  // A stalled result beat holds
  `LJFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "out beat changed while stalled")

  // An accepted pair keeps the input closed in the next cycle
  `LJFA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input reopened right after accept")

  // A result only appears at the end of a pair's work
  `LJFA_ASSERT_SAME(a_emit_from_work, $rose(out_valid), $past(!in_ready), "result raised while idle")

endmodule

bind lennard_jones_force_accumulate_unit ljfa_checker u_checker (.*);
